### rtl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// Shared widths, codes and controller/datapath interface types for the
// segregated free-list allocator.
// ----------------------------------------------------------------------------
package sfla_pkg;

    localparam int CLASS_COUNT   = 15;
    localparam int CLASS_W       = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
    localparam int ADDR_W        = 12;
    localparam int HEAP_GRANULES = 1 << ADDR_W;
    localparam int LINK_W        = ADDR_W + 1;
    localparam int SIZE_W        = 8;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 2;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 16;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_ALLOC = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_MISS     = 2'd1,
        STATUS_BAD_SIZE = 2'd2,
        STATUS_RSVD     = 2'd3
    } status_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic exec;        // latch the result status, clear the split flag
        logic push_add;    // push the added chunk
        logic clear;       // empty every list
        logic pop_read;    // latch the hit class and start the link read
        logic pop;         // unlink the popped chunk
        logic push_split;  // push the remainder
        logic load_out;    // move the result into the output register
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic add_ok;
        logic alloc_hit;
        logic is_clear;
        logic split_needed;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl
// Sequencer for one item at a time: execute, pop, split, respond.
// ----------------------------------------------------------------------------
module sfla_ctrl
    import sfla_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_stat_t   stat,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_POP   = 5'b00100,
        S_SPLIT = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec     = 1'b1;
                cmd.push_add = stat.add_ok;
                cmd.clear    = stat.is_clear;
                cmd.pop_read = stat.alloc_hit;
                state_next   = stat.alloc_hit ? S_POP : S_DONE;
            end
            S_POP: begin
                cmd.pop    = 1'b1;
                state_next = stat.split_needed ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                cmd.push_split = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_split_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SPLIT |-> $past(state_reg) == S_POP)
        else $error("split step not preceded by pop");

    a_hold_done: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE && !stat.out_free |=> state_reg == S_DONE)
        else $error("result left before output register was free");

    a_load_only_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> stat.out_free)
        else $error("output register overwritten");

endmodule

### rtl/sfla_datapath.sv
// ----------------------------------------------------------------------------
// sfla_datapath
// List heads, non-empty flags, link memory, class search and result register.
// ----------------------------------------------------------------------------
module sfla_datapath
    import sfla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_cmd_t            cmd,
    output dp_stat_t             stat,
    input  logic [OP_W-1:0]      in_op,
    input  logic [SIZE_W-1:0]    in_size,
    input  logic [ADDR_W-1:0]    in_addr,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic [STATUS_W-1:0]  m_tuser
);

    logic [OP_W-1:0]        op_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic [ADDR_W-1:0]      addr_reg;
    logic [CLASS_W-1:0]     class_reg;
    logic [ADDR_W-1:0]      chunk_reg;
    logic [ADDR_W-1:0]      heads_reg [CLASS_COUNT];
    logic [CLASS_COUNT-1:0] nonempty_reg;
    logic [LINK_W-1:0]      link_mem  [HEAP_GRANULES];
    logic [LINK_W-1:0]      link_rd_reg;
    logic [STATUS_W-1:0]    res_status_reg;
    logic                   res_split_reg;
    logic                   m_tvalid_reg;
    logic [M_TDATA_W-1:0]   m_tdata_reg;
    logic [STATUS_W-1:0]    m_tuser_reg;

    logic                   size_in_range;
    logic                   hit;
    logic [CLASS_W-1:0]     hit_class;
    logic [STATUS_W-1:0]    status_next;
    logic                   do_push;
    logic [CLASS_W-1:0]     push_class;
    logic [ADDR_W-1:0]      push_addr;
    logic [LINK_W-1:0]      push_link;

    assign size_in_range = (size_reg != '0) && (size_reg <= SIZE_W'(CLASS_COUNT));

    // lowest non-empty class at or above the requested one
    always_comb begin
        hit       = 1'b0;
        hit_class = '0;
        for (int i = CLASS_COUNT - 1; i >= 0; i--) begin
            if (nonempty_reg[i] && ((SIZE_W'(i) + SIZE_W'(1)) >= size_reg)) begin
                hit       = 1'b1;
                hit_class = CLASS_W'(i);
            end
        end
    end

    always_comb begin
        case (op_t'(op_reg))
            OP_ADD:   status_next = size_in_range ? STATUS_OK : STATUS_BAD_SIZE;
            OP_ALLOC: begin
                if (size_reg == '0) begin
                    status_next = STATUS_BAD_SIZE;
                end else if (!size_in_range || !hit) begin
                    status_next = STATUS_MISS;
                end else begin
                    status_next = STATUS_OK;
                end
            end
            OP_CLEAR: status_next = STATUS_OK;
            default:  status_next = STATUS_BAD_SIZE;
        endcase
    end

    assign stat.add_ok       = (op_t'(op_reg) == OP_ADD) && size_in_range;
    assign stat.alloc_hit    = (op_t'(op_reg) == OP_ALLOC) && size_in_range && hit;
    assign stat.is_clear     = (op_t'(op_reg) == OP_CLEAR);
    assign stat.split_needed = (SIZE_W'(class_reg) >= size_reg);
    assign stat.out_free     = !m_tvalid_reg || m_tready;

    // shared push: added chunk or split remainder
    assign do_push    = cmd.push_add || cmd.push_split;
    assign push_class = cmd.push_split ? CLASS_W'(SIZE_W'(class_reg) - size_reg)
                                       : CLASS_W'(size_reg - SIZE_W'(1));
    assign push_addr  = cmd.push_split ? (chunk_reg + ADDR_W'(size_reg)) : addr_reg;
    assign push_link  = nonempty_reg[push_class] ? {1'b1, heads_reg[push_class]}
                                                 : LINK_W'(0);

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= in_op;
            size_reg <= in_size;
            addr_reg <= in_addr;
        end
        if (cmd.pop_read) begin
            class_reg <= hit_class;
            chunk_reg <= heads_reg[hit_class];
        end
        if (do_push) begin
            heads_reg[push_class] <= push_addr;
        end
        if (cmd.pop && link_rd_reg[ADDR_W]) begin
            heads_reg[class_reg] <= link_rd_reg[ADDR_W-1:0];
        end
        if (cmd.exec) begin
            res_status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            link_mem[push_addr] <= push_link;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pop_read) begin
            link_rd_reg <= link_mem[heads_reg[hit_class]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg  <= '0;
            res_split_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.clear) begin
                nonempty_reg <= '0;
            end else begin
                if (cmd.pop && !link_rd_reg[ADDR_W]) begin
                    nonempty_reg[class_reg] <= 1'b0;
                end
                if (do_push) begin
                    nonempty_reg[push_class] <= 1'b1;
                end
            end
            if (cmd.exec) begin
                res_split_reg <= 1'b0;
            end else if (cmd.push_split) begin
                res_split_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_tuser_reg <= res_status_reg;
            m_tdata_reg <= M_TDATA_W'({res_split_reg,
                (res_status_reg == STATUS_OK && op_t'(op_reg) == OP_ALLOC)
                    ? chunk_reg : ADDR_W'(0)});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_push_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        do_push |=> nonempty_reg[$past(push_class)])
        else $error("pushed class still marked empty");

    a_grant_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tuser_reg != STATUS_OK |-> m_tdata_reg[ADDR_W-1:0] == '0)
        else $error("address granted on a failed item");

    a_split_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_tdata_reg[ADDR_W] |-> m_tuser_reg == STATUS_OK)
        else $error("split reported on a failed item");

endmodule

### rtl/segregated_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// segregated_free_list_allocator_top
// Segregated-fit allocator: one LIFO free list per granule size class.
// ----------------------------------------------------------------------------
//  channel  dir  ports                      payload
//  s_       in   tvalid tready tdata tuser  operation, size_units, chunk_address
//  m_       out  tvalid tready tdata tuser  status, granted_address, split_done
//
//  Steps: add, clear, miss and bad size go through accept, execute and respond;
//  an allocation hit adds a pop step, and a split step when the remainder is
//  pushed back. The registered read of the single link memory sets the pop
//  step, the remainder push the split step.
//  Reset: aresetn empties every list; heads and links hold stale data.
//  Stalls: one item is in work at a time; a finished result moves into the
//  output register once that is free, and the next item is taken the cycle
//  after. While m_tready is low the result waits there, and a following
//  finished item holds in the sequencer until the register has emptied.
// ----------------------------------------------------------------------------
module segregated_free_list_allocator_top
    import sfla_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] size_units, [19:8] chunk_address
    input  logic [OP_W-1:0]      s_tuser,   // [1:0] operation
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [11:0] granted_address, [12] split_done
    output logic [STATUS_W-1:0]  m_tuser    // [1:0] status
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    // sequencer: accept, execute, pop, split, respond
    sfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // lists, link memory and result register; unpack the input item here
    sfla_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .in_op    (s_tuser),
        .in_size  (s_tdata[SIZE_W-1:0]),
        .in_addr  (s_tdata[SIZE_W+ADDR_W-1:SIZE_W]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
